/* hw/rtl/etc_pkg.sv */
// Shared constants, month table and leap-year helpers for the epoch to calendar converter.
// Used by the day split, date, clock and top-level modules. Depends on nothing.
package etc_pkg;

   // Register stages from the input to the output register.
   localparam int PIPE_DEPTH = 7;

   localparam logic [31:0] SECS_PER_DAY = 32'd86400;
   // floor(2^48 / 86400); the quotient estimate is low by at most one.
   localparam logic [31:0] DAY_RECIP    = 32'd3257812230;

   localparam logic [15:0] DAYS_PER_YEAR = 16'd365;
   // ceil(2^24 / 365), exact for any day count the input can produce.
   localparam logic [15:0] YEAR_RECIP    = 16'd45965;
   localparam int          YEAR_SHIFT    = 24;

   localparam logic [16:0] EPOCH_WEEKDAY = 17'd4;
   // ceil(2^19 / 7), exact below 104857.
   localparam logic [16:0] WEEK_RECIP    = 17'd74899;
   localparam int          WEEK_SHIFT    = 19;

   localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
   // ceil(2^28 / 3600), exact below 125203.
   localparam logic [16:0] HOUR_RECIP    = 17'd74566;
   localparam int          HOUR_SHIFT    = 28;

   localparam logic [11:0] SECS_PER_MIN  = 12'd60;
   // ceil(2^18 / 60), exact below 4681.
   localparam logic [12:0] MIN_RECIP     = 13'd4370;
   localparam int          MIN_SHIFT     = 18;

   localparam logic [7:0]  EPOCH_YEAR_OFS = 8'd70;
   // Year offset from 1970 of 2100, the only non-leap century in range.
   localparam logic [7:0]  NONLEAP_CENTURY_OFS = 8'd130;

   localparam logic [8:0] MONTH_START [12] = '{
      9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   // Leap test for the year 1970 + ofs. Inside 1970..2106 the only century
   // years are 2000, which is leap, and 2100, which is not.
   function automatic logic is_leap_ofs(input logic [7:0] ofs);
      logic [7:0] shifted;
      shifted = ofs + 8'd2;
      return (shifted[1:0] == 2'b00) && (ofs != NONLEAP_CENTURY_OFS);
   endfunction

   // Leap days in the years 1970 .. 1969 + ofs.
   function automatic logic [5:0] leaps_since_epoch(input logic [7:0] ofs);
      logic [8:0] next_ofs;
      logic [5:0] fours;
      next_ofs = {1'b0, ofs} + 9'd1;
      fours    = 6'(next_ofs >> 2);
      return fours - 6'(ofs > NONLEAP_CENTURY_OFS);
   endfunction

   // Zero-based day of year on which month idx begins.
   function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
      return MONTH_START[idx] + 9'((leap && (idx >= 4'd2)) ? 1 : 0);
   endfunction

endpackage

/* hw/rtl/epoch_seconds_to_calendar.sv */
// Epoch seconds to Gregorian calendar converter, top level.
// Instantiates etc_day_split, etc_date and etc_clock; depends on etc_pkg.
//
// The req_ channel takes one unsigned 32-bit count of seconds since
// 1970-01-01 00:00:00 per item. The rsp_ channel returns one item per
// request with year since 1900, month, day of month, hour, minute, second,
// weekday and one-based day of year.
//
// The datapath is a seven-stage pipeline: three stages split off whole days,
// then the date and time-of-day paths run side by side for four more. The
// first stage loads at the edge that takes an item, which then passes through
// every stage register to rsp_valid. A new item can be taken every cycle while
// the output does not stall. The stage depth is set by the reciprocal multipliers,
// each of which is followed by a register before its back-multiply.
//
// All stages advance together. When rsp_valid is high and rsp_ready is low the
// whole pipeline holds, req_ready drops, and nothing is lost or repeated.
// Reset clears the stage valid bits; the block keeps no other state.
module epoch_seconds_to_calendar (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_years_since_1900,
   output logic [3:0]  rsp_month_index,
   output logic [4:0]  rsp_day_of_month,
   output logic [4:0]  rsp_hour_of_day,
   output logic [5:0]  rsp_minute_of_hour,
   output logic [5:0]  rsp_second_of_minute,
   output logic [2:0]  rsp_weekday,
   output logic [8:0]  rsp_day_of_year
);
   import etc_pkg::*;

   logic [PIPE_DEPTH-1:0] valid_ff, valid_in;
   logic                  advance;
   logic [15:0]           days;
   logic [16:0]           sec_of_day;

   assign advance   = !valid_ff[PIPE_DEPTH-1] || rsp_ready;
   assign req_ready = advance;
   assign valid_in  = {valid_ff[PIPE_DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff[PIPE_DEPTH-1];

   etc_day_split u_day_split (
      .clock         (clock),
      .advance       (advance),
      .epoch_seconds (req_epoch_seconds),
      .days          (days),
      .sec_of_day    (sec_of_day)
   );

   etc_date u_date (
      .clock            (clock),
      .advance          (advance),
      .days             (days),
      .years_since_1900 (rsp_years_since_1900),
      .month_index      (rsp_month_index),
      .day_of_month     (rsp_day_of_month),
      .weekday          (rsp_weekday),
      .day_of_year      (rsp_day_of_year)
   );

   etc_clock u_clock (
      .clock            (clock),
      .advance          (advance),
      .sec_of_day       (sec_of_day),
      .hour_of_day      (rsp_hour_of_day),
      .minute_of_hour   (rsp_minute_of_hour),
      .second_of_minute (rsp_second_of_minute)
   );

endmodule

/* hw/rtl/etc_day_split.sv */
// Three-stage split of the epoch seconds into whole days and the second of the day.
// Uses a reciprocal multiply with one correction step. Depends on etc_pkg.
module etc_day_split (
   input  logic        clock,
   input  logic        advance,
   input  logic [31:0] epoch_seconds,
   output logic [15:0] days,
   output logic [16:0] sec_of_day
);
   import etc_pkg::*;

   logic [63:0] prod_ff, prod_in;
   logic [31:0] secs_ff;
   logic [15:0] quot_ff, quot_in;
   logic [17:0] rem_ff, rem_in;
   logic [15:0] days_ff, days_in;
   logic [16:0] sod_ff, sod_in;

   assign prod_in = 64'(epoch_seconds) * 64'(DAY_RECIP);

   always_comb begin
      quot_in = prod_ff[63:48];
      rem_in  = 18'(secs_ff - 32'(quot_in) * SECS_PER_DAY);
   end

   // The estimate may fall one day short; fix it up here.
   always_comb begin
      if (rem_ff >= 18'(SECS_PER_DAY)) begin
         days_in = quot_ff + 16'd1;
         sod_in  = 17'(rem_ff - 18'(SECS_PER_DAY));
      end else begin
         days_in = quot_ff;
         sod_in  = rem_ff[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         secs_ff <= epoch_seconds;
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
         days_ff <= days_in;
         sod_ff  <= sod_in;
      end
   end

   assign days       = days_ff;
   assign sec_of_day = sod_ff;

endmodule

/* hw/rtl/etc_date.sv */
// Four-stage conversion of a day count into year, month, day, weekday and day of year.
// Year from a reciprocal estimate with one correction, month from parallel compares.
// Depends on etc_pkg.
module etc_date (
   input  logic        clock,
   input  logic        advance,
   input  logic [15:0] days,
   output logic [7:0]  years_since_1900,
   output logic [3:0]  month_index,
   output logic [4:0]  day_of_month,
   output logic [2:0]  weekday,
   output logic [8:0]  day_of_year
);
   import etc_pkg::*;

   // Stage 1: reciprocal products for the year and the weekday.
   logic [31:0] yprod_ff, yprod_in;
   logic [33:0] wprod_ff, wprod_in;
   logic [15:0] days1_ff;
   logic [16:0] wnum1_ff, wnum_in;

   // Stage 2: year offset estimate and the day within that year.
   logic [7:0]  ofs_ff, ofs_in;
   logic [17:0] rem_ff, rem_in;
   logic [2:0]  wd2_ff, wd_in;
   logic [14:0] wquot;

   // Stage 3: corrected year.
   logic [7:0]  year_ff, year_in;
   logic        leap_ff, leap_in;
   logic [8:0]  doy_ff, doy_in;
   logic [2:0]  wd3_ff;
   logic [7:0]  ofs_fix;
   logic [17:0] doy_wide;

   // Stage 4: month walk and output register.
   logic [7:0]  year4_ff;
   logic [3:0]  mon_ff, mon_in;
   logic [4:0]  dom_ff, dom_in;
   logic [2:0]  wd4_ff;
   logic [8:0]  yday_ff, yday_in;

   always_comb begin
      wnum_in  = {1'b0, days} + EPOCH_WEEKDAY;
      yprod_in = 32'(days) * 32'(YEAR_RECIP);
      wprod_in = 34'(wnum_in) * 34'(WEEK_RECIP);
   end

   always_comb begin
      ofs_in = yprod_ff[YEAR_SHIFT +: 8];
      wquot  = wprod_ff[WEEK_SHIFT +: 15];
      wd_in  = 3'(wnum1_ff - 17'(wquot) * 17'd7);
      rem_in = {2'b00, days1_ff} - 18'(16'(ofs_in) * DAYS_PER_YEAR)
               - 18'(leaps_since_epoch(ofs_in));
   end

   // A negative remainder means the estimate overshot by one year.
   always_comb begin
      if (rem_ff[17]) begin
         ofs_fix  = ofs_ff - 8'd1;
         doy_wide = rem_ff + 18'(DAYS_PER_YEAR) + 18'(is_leap_ofs(ofs_fix));
      end else begin
         ofs_fix  = ofs_ff;
         doy_wide = rem_ff;
      end
      year_in = EPOCH_YEAR_OFS + ofs_fix;
      leap_in = is_leap_ofs(ofs_fix);
      doy_in  = doy_wide[8:0];
   end

   // The month is the last one whose first day is not past the day of year.
   always_comb begin
      mon_in = 4'd0;
      for (int i = 1; i < 12; i++) begin
         if (month_start(4'(i), leap_ff) <= doy_ff) begin
            mon_in = 4'(i);
         end
      end
      dom_in  = 5'(doy_ff - month_start(mon_in, leap_ff) + 9'd1);
      yday_in = doy_ff + 9'd1;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         yprod_ff <= yprod_in;
         wprod_ff <= wprod_in;
         days1_ff <= days;
         wnum1_ff <= wnum_in;
         ofs_ff   <= ofs_in;
         rem_ff   <= rem_in;
         wd2_ff   <= wd_in;
         year_ff  <= year_in;
         leap_ff  <= leap_in;
         doy_ff   <= doy_in;
         wd3_ff   <= wd2_ff;
         year4_ff <= year_ff;
         mon_ff   <= mon_in;
         dom_ff   <= dom_in;
         wd4_ff   <= wd3_ff;
         yday_ff  <= yday_in;
      end
   end

   assign years_since_1900 = year4_ff;
   assign month_index      = mon_ff;
   assign day_of_month     = dom_ff;
   assign weekday          = wd4_ff;
   assign day_of_year      = yday_ff;

endmodule

/* hw/rtl/etc_clock.sv */
// Four-stage split of the second of the day into hour, minute and second.
// Each division is a reciprocal multiply followed by a back-multiply. Depends on etc_pkg.
module etc_clock (
   input  logic        clock,
   input  logic        advance,
   input  logic [16:0] sec_of_day,
   output logic [4:0]  hour_of_day,
   output logic [5:0]  minute_of_hour,
   output logic [5:0]  second_of_minute
);
   import etc_pkg::*;

   logic [33:0] hprod_ff, hprod_in;
   logic [16:0] sod1_ff;
   logic [4:0]  hour2_ff, hour_in;
   logic [11:0] rest2_ff, rest_in;
   logic [23:0] mprod_ff, mprod_in;
   logic [11:0] rest3_ff;
   logic [4:0]  hour3_ff;
   logic [4:0]  hour4_ff;
   logic [5:0]  min_ff, min_in;
   logic [5:0]  sec_ff, sec_in;

   assign hprod_in = 34'(sec_of_day) * 34'(HOUR_RECIP);

   always_comb begin
      hour_in = hprod_ff[HOUR_SHIFT +: 5];
      rest_in = 12'(sod1_ff - 17'(hour_in) * SECS_PER_HOUR);
   end

   assign mprod_in = 24'(rest2_ff) * 24'(MIN_RECIP);

   always_comb begin
      min_in = mprod_ff[MIN_SHIFT +: 6];
      sec_in = 6'(rest3_ff - 12'(min_in) * SECS_PER_MIN);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hprod_ff <= hprod_in;
         sod1_ff  <= sec_of_day;
         hour2_ff <= hour_in;
         rest2_ff <= rest_in;
         mprod_ff <= mprod_in;
         rest3_ff <= rest2_ff;
         hour3_ff <= hour2_ff;
         hour4_ff <= hour3_ff;
         min_ff   <= min_in;
         sec_ff   <= sec_in;
      end
   end

   assign hour_of_day      = hour4_ff;
   assign minute_of_hour   = min_ff;
   assign second_of_minute = sec_ff;

endmodule

/* hw/rtl/etc_checker.sv */
// Port-level checks for the epoch to calendar converter, bound to the top level.
// Sees only the top-level ports; depends on nothing else.
module etc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_years_since_1900,
   input logic [3:0]  rsp_month_index,
   input logic [4:0]  rsp_day_of_month,
   input logic [4:0]  rsp_hour_of_day,
   input logic [5:0]  rsp_minute_of_hour,
   input logic [5:0]  rsp_second_of_minute,
   input logic [2:0]  rsp_weekday,
   input logic [8:0]  rsp_day_of_year
);

   // A result item that is not taken stays valid, and its year, day of year, second and weekday stay put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable(rsp_years_since_1900) && $stable(rsp_day_of_year)
         && $stable(rsp_second_of_minute) && $stable(rsp_weekday))
      else $error("result item changed while stalled");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item valid after reset");

   // With no result waiting, the pipeline always takes a new item.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with an empty output");

   // Every result lies in the calendar's ranges.
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_month_index <= 4'd11 && rsp_day_of_month >= 5'd1
         && rsp_hour_of_day <= 5'd23 && rsp_minute_of_hour <= 6'd59
         && rsp_second_of_minute <= 6'd59 && rsp_weekday <= 3'd6)
      else $error("time or date field out of range");

   a_year_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_day_of_year >= 9'd1 && rsp_day_of_year <= 9'd366
         && rsp_years_since_1900 >= 8'd70 && rsp_years_since_1900 <= 8'd206)
      else $error("year or day of year out of range");

endmodule

bind epoch_seconds_to_calendar etc_checker u_etc_checker (.*);

/* verif/testbench.sv */
// Self-checking testbench for epoch_seconds_to_calendar, the epoch seconds to calendar converter.
// Needs only the RTL. A scoreboard class predicts each calendar date, and the driver
// and receiver stall at random.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD   = 20;
   localparam int RESET_CYCLES   = 12;
   localparam int RANDOM_ITEMS   = 750;
   localparam int CALM_ITEMS     = 200;
   localparam int IDLE_PERCENT   = 17;
   localparam int DRAIN_CYCLES   = 20;
   localparam int CYCLE_LIMIT    = 200000;

   typedef struct packed {
      logic [7:0] years_since_1900;
      logic [3:0] month_index;
      logic [4:0] day_of_month;
      logic [4:0] hour_of_day;
      logic [5:0] minute_of_hour;
      logic [5:0] second_of_minute;
      logic [2:0] weekday;
      logic [8:0] day_of_year;
   } calendar_date_type;

   class calendar_scoreboard;
      calendar_date_type pending_dates [$];
      int error_count;

      function new();
         error_count = 0;
      endfunction

      function int leaps_through(int year);
         return year / 4 - year / 100 + year / 400;
      endfunction

      function bit is_leap_year(int year);
         return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
      endfunction

      // Days from 1970-01-01 to January 1 of the given year.
      function int first_day_of_year(int year);
         return (year - 1970) * 365 + leaps_through(year - 1) - leaps_through(1969);
      endfunction

      function calendar_date_type convert(logic [31:0] epoch_seconds);
         int unsigned       day_count;
         int unsigned       sec_of_day;
         int                days;
         int                year;
         int                month;
         int                month_len;
         int                month_days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
         calendar_date_type date;
         day_count  = epoch_seconds / 86400;
         sec_of_day = epoch_seconds - day_count * 86400;
         // 1970-01-01 was a Thursday.
         date.weekday = 3'((day_count + 4) % 7);
         days = int'(day_count);
         // The estimate from days / 365 can be one year too high once leap days are counted.
         year = 1970 + days / 365;
         days -= first_day_of_year(year);
         if (days < 0) begin
            year -= 1;
            days += 365 + int'(is_leap_year(year));
         end
         date.day_of_year = 9'(days + 1);
         for (month = 0; month < 11; month++) begin
            month_len = month_days[month] + ((month == 1 && is_leap_year(year)) ? 1 : 0);
            if (days < month_len)
               break;
            days -= month_len;
         end
         date.years_since_1900 = 8'(year - 1900);
         date.month_index      = 4'(month);
         date.day_of_month     = 5'(days + 1);
         date.hour_of_day      = 5'(sec_of_day / 3600);
         date.minute_of_hour   = 6'((sec_of_day % 3600) / 60);
         date.second_of_minute = 6'(sec_of_day % 60);
         return date;
      endfunction

      function void note_request(logic [31:0] epoch_seconds);
         pending_dates.push_back(convert(epoch_seconds));
      endfunction

      function void compare_field(string name, int unsigned expected_value,
                                  int unsigned actual_value);
         if (expected_value != actual_value) begin
            $error("%s: expected %0d, got %0d", name, expected_value, actual_value);
            error_count++;
         end
      endfunction

      function void check_response(calendar_date_type actual);
         calendar_date_type expected;
         if (pending_dates.size() == 0) begin
            $error("response item arrived with no request outstanding");
            error_count++;
            return;
         end
         expected = pending_dates.pop_front();
         compare_field("years_since_1900", expected.years_since_1900, actual.years_since_1900);
         compare_field("month_index", expected.month_index, actual.month_index);
         compare_field("day_of_month", expected.day_of_month, actual.day_of_month);
         compare_field("hour_of_day", expected.hour_of_day, actual.hour_of_day);
         compare_field("minute_of_hour", expected.minute_of_hour, actual.minute_of_hour);
         compare_field("second_of_minute", expected.second_of_minute, actual.second_of_minute);
         compare_field("weekday", expected.weekday, actual.weekday);
         compare_field("day_of_year", expected.day_of_year, actual.day_of_year);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_epoch_seconds = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_years_since_1900;
   logic [3:0]  rsp_month_index;
   logic [4:0]  rsp_day_of_month;
   logic [4:0]  rsp_hour_of_day;
   logic [5:0]  rsp_minute_of_hour;
   logic [5:0]  rsp_second_of_minute;
   logic [2:0]  rsp_weekday;
   logic [8:0]  rsp_day_of_year;

   int                 idle_pct = IDLE_PERCENT;
   int                 cycle_count = 0;
   calendar_scoreboard date_board = new();

   epoch_seconds_to_calendar dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_epoch_seconds    (req_epoch_seconds),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_years_since_1900 (rsp_years_since_1900),
      .rsp_month_index      (rsp_month_index),
      .rsp_day_of_month     (rsp_day_of_month),
      .rsp_hour_of_day      (rsp_hour_of_day),
      .rsp_minute_of_hour   (rsp_minute_of_hour),
      .rsp_second_of_minute (rsp_second_of_minute),
      .rsp_weekday          (rsp_weekday),
      .rsp_day_of_year      (rsp_day_of_year)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // The receiver drops ready at random while idling is enabled.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         date_board.note_request(req_epoch_seconds);
      if (!reset && rsp_valid && rsp_ready)
         date_board.check_response('{rsp_years_since_1900, rsp_month_index, rsp_day_of_month,
                                     rsp_hour_of_day, rsp_minute_of_hour,
                                     rsp_second_of_minute, rsp_weekday, rsp_day_of_year});
   end

   // Presents one item and returns at the rising edge that accepts it.
   task automatic send_epoch(input logic [31:0] epoch_seconds);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_epoch_seconds <= epoch_seconds;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   initial begin
      logic [31:0] directed_seconds [$];
      logic [31:0] epoch_seconds;
      longint      candidate;
      int          year;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_seconds = '{
         32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
         32'd94608000,    // 1972-12-31, where the year estimate runs one year ahead
         32'd94607999, 32'd946684799, 32'd951782400, 32'd951868800,
         32'd978220800,   // 2000-12-31, day 366 of a leap year
         32'd4102444800, 32'd4107456000, 32'd4107542400,   // 2100 is not a leap year
         32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
         32'hFFFF_FFFE, 32'hFFFF_FFFF
      };
      foreach (directed_seconds[i])
         send_epoch(directed_seconds[i]);

      for (int item = 0; item < RANDOM_ITEMS; item++) begin
         idle_pct = (item < CALM_ITEMS) ? 0 : IDLE_PERCENT;
         year     = $urandom_range(1971, 2106);
         case ($urandom_range(0, 3))
            0: candidate = $urandom;
            // Around New Year, where the year correction and December end meet.
            1: candidate = longint'(date_board.first_day_of_year(year)) * 86400
                           + $urandom_range(0, 4 * 86400) - 2 * 86400;
            // Around the end of February.
            2: candidate = longint'(date_board.first_day_of_year(year) + 57) * 86400
                           + $urandom_range(0, 4 * 86400);
            default: candidate = longint'(date_board.first_day_of_year(year)
                                          + $urandom_range(0, 365)) * 86400
                                 + $urandom_range(0, 86399);
         endcase
         epoch_seconds = (candidate > 64'hFFFF_FFFF) ? $urandom : 32'(candidate);
         send_epoch(epoch_seconds);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (date_board.pending_dates.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (date_board.error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
